// ----- sv/dcfd_pkg.sv -----
// Shared types, constants and helper functions for the DCF77 frame decoder.
// No dependencies; imported by dcf77_pulse_frame_decoder.
`default_nettype none
package dcfd_pkg;

	localparam int FRAME_SLOTS = 61;
	localparam int SLOT_W      = $clog2(FRAME_SLOTS);
	localparam int CFG_W       = 12;
	localparam int CFG_N       = 6;
	localparam int CFG_AW      = 3;
	localparam int TIME_W      = 32;
	localparam int SYM_W       = 2;
	localparam int EV_W        = 3;
	localparam int BCD_W       = 8;
	localparam int OUT_TDATA_W = 48;

	// register indexes
	typedef enum logic [CFG_AW-1:0] {
		REG_ZERO_MIN = 3'd0,
		REG_ZERO_MAX = 3'd1,
		REG_ONE_MIN  = 3'd2,
		REG_ONE_MAX  = 3'd3,
		REG_SYNC_MIN = 3'd4,
		REG_SYNC_MAX = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0] ZERO_MIN_RST = 12'd80;
	localparam logic [CFG_W-1:0] ZERO_MAX_RST = 12'd130;
	localparam logic [CFG_W-1:0] ONE_MIN_RST  = 12'd180;
	localparam logic [CFG_W-1:0] ONE_MAX_RST  = 12'd230;
	localparam logic [CFG_W-1:0] SYNC_MIN_RST = 12'd1800;
	localparam logic [CFG_W-1:0] SYNC_MAX_RST = 12'd2200;

	typedef enum logic [SYM_W-1:0] {
		SYM_UNKNOWN = 2'd0,
		SYM_ZERO    = 2'd1,
		SYM_ONE     = 2'd2,
		SYM_SYNC    = 2'd3
	} sym_t;

	typedef enum logic [EV_W-1:0] {
		EV_UNCLASS = 3'd0,
		EV_BIT     = 3'd1,
		EV_VALID   = 3'd2,
		EV_REJECT  = 3'd3,
		EV_RISE    = 3'd4
	} ev_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_EVAL,
		ST_WALK,
		ST_TAIL,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		FLD_NONE,
		FLD_MIN,
		FLD_HOUR,
		FLD_DAY,
		FLD_WDAY,
		FLD_MON,
		FLD_YEAR
	} fld_t;

	typedef struct packed {
		fld_t       fld;
		logic [2:0] k;
	} fld_sel_t;

	// special slots of the time code
	localparam logic [SLOT_W-1:0] SLOT_START  = SLOT_W'(0);
	localparam logic [SLOT_W-1:0] SLOT_ANT    = SLOT_W'(15);
	localparam logic [SLOT_W-1:0] SLOT_ZCHG   = SLOT_W'(16);
	localparam logic [SLOT_W-1:0] SLOT_CEST   = SLOT_W'(17);
	localparam logic [SLOT_W-1:0] SLOT_CET    = SLOT_W'(18);
	localparam logic [SLOT_W-1:0] SLOT_LEAP   = SLOT_W'(19);
	localparam logic [SLOT_W-1:0] SLOT_TSTART = SLOT_W'(20);
	localparam logic [SLOT_W-1:0] SLOT_MIN0   = SLOT_W'(21);
	localparam logic [SLOT_W-1:0] SLOT_PMIN   = SLOT_W'(28);
	localparam logic [SLOT_W-1:0] SLOT_HOUR0  = SLOT_W'(29);
	localparam logic [SLOT_W-1:0] SLOT_PHOUR  = SLOT_W'(35);
	localparam logic [SLOT_W-1:0] SLOT_DAY0   = SLOT_W'(36);
	localparam logic [SLOT_W-1:0] SLOT_WDAY0  = SLOT_W'(42);
	localparam logic [SLOT_W-1:0] SLOT_MON0   = SLOT_W'(45);
	localparam logic [SLOT_W-1:0] SLOT_YEAR0  = SLOT_W'(50);
	localparam logic [SLOT_W-1:0] SLOT_PDATE  = SLOT_W'(58);
	localparam logic [SLOT_W-1:0] MIN_SLOTS   = SLOT_W'(59);
	localparam logic [SLOT_W-1:0] SLOT_LAST   = SLOT_W'(FRAME_SLOTS - 1);

	typedef struct packed {
		logic       leap_pending;
		logic       zone_change;
		logic [1:0] zone;
		logic [1:0] status;
		logic [7:0] year;
		logic [4:0] month;
		logic [2:0] weekday;
		logic [5:0] day;
		logic [5:0] hour;
		logic [6:0] minute;
		logic       bit_value;
	} res_data_t;

	localparam int RES_W = $bits(res_data_t);

	localparam logic [1:0] ZONE_UNKNOWN = 2'd0;
	localparam logic [1:0] ZONE_CET     = 2'd1;
	localparam logic [1:0] ZONE_CEST    = 2'd2;
	localparam logic [1:0] STAT_NORMAL  = 2'd0;
	localparam logic [1:0] STAT_BACKUP  = 2'd1;
	localparam logic [1:0] STAT_ZONE    = 2'd2;

	function automatic logic [BCD_W-1:0] bcd_weight(input logic [2:0] k);
		logic [BCD_W-1:0] w;
		case (k)
			3'd0:    w = 8'd1;
			3'd1:    w = 8'd2;
			3'd2:    w = 8'd4;
			3'd3:    w = 8'd8;
			3'd4:    w = 8'd10;
			3'd5:    w = 8'd20;
			3'd6:    w = 8'd40;
			default: w = 8'd80;
		endcase
		return w;
	endfunction

	// which BCD field a slot feeds and its digit weight position
	function automatic fld_sel_t slot_field(input logic [SLOT_W-1:0] idx);
		fld_sel_t         r;
		logic [SLOT_W-1:0] base;
		r.fld = FLD_NONE;
		base  = SLOT_START;
		if (idx >= SLOT_MIN0 && idx < SLOT_PMIN) begin
			r.fld = FLD_MIN;
			base  = SLOT_MIN0;
		end else if (idx >= SLOT_HOUR0 && idx < SLOT_PHOUR) begin
			r.fld = FLD_HOUR;
			base  = SLOT_HOUR0;
		end else if (idx >= SLOT_DAY0 && idx < SLOT_WDAY0) begin
			r.fld = FLD_DAY;
			base  = SLOT_DAY0;
		end else if (idx >= SLOT_WDAY0 && idx < SLOT_MON0) begin
			r.fld = FLD_WDAY;
			base  = SLOT_WDAY0;
		end else if (idx >= SLOT_MON0 && idx < SLOT_YEAR0) begin
			r.fld = FLD_MON;
			base  = SLOT_MON0;
		end else if (idx >= SLOT_YEAR0 && idx < SLOT_PDATE) begin
			r.fld = FLD_YEAR;
			base  = SLOT_YEAR0;
		end
		r.k = 3'(idx - base);
		return r;
	endfunction

	// open window test: lo < d < hi
	function automatic logic in_window(input logic [TIME_W-1:0] d,
			input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
		return (d > TIME_W'(lo)) && (d < TIME_W'(hi));
	endfunction

endpackage
`default_nettype wire

// ----- sv/dcfd_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module dcfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- sv/dcf77_pulse_frame_decoder.sv -----
// DCF77 time code decoder top level: edge stream in, one result beat per edge out.
// Depends on dcfd_pkg and dcfd_ram.
`default_nettype none
// Each input beat is one receiver edge: tuser says rising (1) or falling (0),
// tdata carries its millisecond timestamp. Every edge yields exactly one
// result beat. A falling edge measures the pulse width from the last rising
// edge and, if it falls strictly inside the zero or one window, writes that
// symbol into the current slot of a 61-entry symbol RAM; the slot index then
// advances and saturates at the last slot. A rising edge whose gap to the
// previous rising edge lies strictly inside the sync window is the minute
// marker: it writes a sync symbol, rewinds the slot index and walks slots
// 0..58 through the RAM's single read port, one slot per cycle, to check the
// start, time-start and parity bits and accumulate the BCD fields through one
// shared 8-bit adder. A falling edge or a plain rising edge passes through the
// DIFF, EVAL and OUT states; a minute marker also passes through WALK, TAIL
// and FIN, with WALK issuing the 59-slot walk. The input is not ready while an edge is
// being processed; a finished result sits in the output register, so the
// next edge may be accepted while it waits. The symbol store reads as
// unknown after reset through per-slot valid flops, so no clearing pass is
// needed. Configuration registers are 12-bit millisecond thresholds written
// through cfg_we/cfg_addr/cfg_data; the user must write them only while the
// block is idle, which the block itself does not enforce; indexes 6 and 7 are ignored.
module dcf77_pulse_frame_decoder (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration
	input  wire logic                            cfg_we,
	input  wire logic [dcfd_pkg::CFG_AW-1:0]     cfg_addr,
	input  wire logic [dcfd_pkg::CFG_W-1:0]      cfg_data,
	// edge stream
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [dcfd_pkg::TIME_W-1:0]     s_tdata,  // [31:0] time_ms
	input  wire logic                            s_tuser,  // [0] edge_rising
	// result stream
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] bit_value, [7:1] minute, [13:8] hour, [19:14] day, [22:20] weekday,
	// [27:23] month, [35:28] year, [37:36] status, [39:38] zone,
	// [40] zone_change, [41] leap_pending, [47:42] zero
	output logic [dcfd_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [dcfd_pkg::EV_W-1:0]            m_tuser   // [2:0] event_res
);

	import dcfd_pkg::*;

	// control
	state_t                 state_q, state_d;
	logic                   primed_q;
	logic [SLOT_W-1:0]      slot_q;
	logic [FRAME_SLOTS-1:0] valid_q;
	logic                   m_tvalid_q;

	// configuration
	logic [CFG_W-1:0]       cfg_q [CFG_N];

	// edge under work
	logic                   rise_q;
	logic [TIME_W-1:0]      time_q;
	logic [TIME_W-1:0]      last_rise_q;
	logic [TIME_W-1:0]      diff_q;

	// frame walk
	logic [SLOT_W-1:0]      walk_q;
	logic                   vld_s1;
	logic [SLOT_W-1:0]      idx_s1;
	logic                   vbit_s1;
	logic                   long_q;
	logic                   ok_q;
	logic [2:0]             par_q;
	logic                   ant_zero_q;
	logic                   zchg_q;
	logic                   s17_one_q, s17_zero_q;
	logic                   s18_one_q, s18_zero_q;
	logic                   leap_q;
	logic [6:0]             min_q;
	logic [5:0]             hour_q;
	logic [5:0]             day_q;
	logic [2:0]             wday_q;
	logic [4:0]             mon_q;
	logic [7:0]             year_q;

	// results
	ev_t                    res_ev_q, m_ev_q;
	res_data_t              res_q, m_data_q;
	res_data_t              res_eval, res_fin;

	// decoded controls
	logic                   in_acc;
	logic                   out_free;
	logic                   is_sync;
	logic                   zero_hit, one_hit;
	logic                   ram_we;
	logic [SYM_W-1:0]       ram_wdata;
	logic [SYM_W-1:0]       ram_rdata;
	sym_t                   sym_s1;
	logic                   one_s1, zero_s1;
	fld_sel_t               fsel;
	logic [BCD_W-1:0]       acc_cur, acc_sum;
	logic                   frame_ok;
	logic                   zone_cet, zone_cest;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// ---------------------------------------------------------------- next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_EVAL;
			ST_EVAL: begin
				if (rise_q && is_sync) state_d = ST_WALK;
				else                   state_d = ST_OUT;
			end
			ST_WALK: begin
				if (walk_q == SLOT_PDATE) state_d = ST_TAIL;
			end
			ST_TAIL: state_d = ST_FIN;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- controls
	always_comb begin
		s_tready  = 1'b0;
		ram_we    = 1'b0;
		ram_wdata = SYM_UNKNOWN;
		case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_EVAL: begin
				if (!rise_q) begin
					// one wins when both windows overlap
					ram_we    = zero_hit || one_hit;
					ram_wdata = one_hit ? SYM_ONE : SYM_ZERO;
				end else if (is_sync) begin
					ram_we    = 1'b1;
					ram_wdata = SYM_SYNC;
				end
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// shared window compare against the registered width or gap
	assign zero_hit = in_window(diff_q, cfg_q[REG_ZERO_MIN], cfg_q[REG_ZERO_MAX]);
	assign one_hit  = in_window(diff_q, cfg_q[REG_ONE_MIN], cfg_q[REG_ONE_MAX]);
	assign is_sync  = in_window(diff_q, cfg_q[REG_SYNC_MIN], cfg_q[REG_SYNC_MAX]);

	// ---------------------------------------------------------------- symbol RAM
	dcfd_ram #(
		.WIDTH (SYM_W),
		.DEPTH (FRAME_SLOTS)
	) u_sym_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata (ram_wdata),
		.raddr (walk_q),
		.rdata (ram_rdata)
	);

	// never-written slots read as unknown
	assign sym_s1  = vbit_s1 ? sym_t'(ram_rdata) : SYM_UNKNOWN;
	assign one_s1  = (sym_s1 == SYM_ONE);
	assign zero_s1 = (sym_s1 == SYM_ZERO);

	// shared BCD adder: add the digit weight into the field the slot feeds
	assign fsel = slot_field(idx_s1);
	always_comb begin
		case (fsel.fld)
			FLD_MIN:  acc_cur = BCD_W'(min_q);
			FLD_HOUR: acc_cur = BCD_W'(hour_q);
			FLD_DAY:  acc_cur = BCD_W'(day_q);
			FLD_WDAY: acc_cur = BCD_W'(wday_q);
			FLD_MON:  acc_cur = BCD_W'(mon_q);
			FLD_YEAR: acc_cur = year_q;
			default:  acc_cur = '0;
		endcase
	end
	assign acc_sum = acc_cur + bcd_weight(fsel.k);

	assign frame_ok  = ok_q && long_q && (par_q == 3'b000);
	assign zone_cet  = s17_zero_q && s18_one_q;
	assign zone_cest = s17_one_q && s18_zero_q;

	// result words: one for a short edge, one for the end of a frame walk
	always_comb begin
		res_eval           = '0;
		res_eval.bit_value = !rise_q && one_hit;
		res_fin            = '0;
		if (frame_ok) begin
			res_fin.minute       = min_q;
			res_fin.hour         = hour_q;
			res_fin.day          = day_q;
			res_fin.weekday      = wday_q;
			res_fin.month        = mon_q;
			res_fin.year         = year_q;
			res_fin.zone_change  = zchg_q;
			res_fin.leap_pending = leap_q;
			if (zone_cet) begin
				res_fin.zone   = ZONE_CET;
				res_fin.status = ant_zero_q ? STAT_NORMAL : STAT_BACKUP;
			end else if (zone_cest) begin
				res_fin.zone   = ZONE_CEST;
				res_fin.status = ant_zero_q ? STAT_NORMAL : STAT_BACKUP;
			end else begin
				res_fin.zone   = ZONE_UNKNOWN;
				res_fin.status = STAT_ZONE;
			end
		end
	end

	// ---------------------------------------------------------------- control regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			primed_q   <= 1'b0;
			slot_q     <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
			vld_s1     <= 1'b0;
			last_rise_q <= '0;
			cfg_q[REG_ZERO_MIN] <= ZERO_MIN_RST;
			cfg_q[REG_ZERO_MAX] <= ZERO_MAX_RST;
			cfg_q[REG_ONE_MIN]  <= ONE_MIN_RST;
			cfg_q[REG_ONE_MAX]  <= ONE_MAX_RST;
			cfg_q[REG_SYNC_MIN] <= SYNC_MIN_RST;
			cfg_q[REG_SYNC_MAX] <= SYNC_MAX_RST;
		end else begin
			state_q <= state_d;
			vld_s1  <= (state_q == ST_WALK);

			if (cfg_we && cfg_addr < CFG_AW'(CFG_N)) begin
				cfg_q[cfg_addr] <= cfg_data;
			end

			// first edge measures from itself
			if (in_acc && !primed_q) begin
				last_rise_q <= s_tdata;
				primed_q    <= 1'b1;
			end

			if (ram_we) begin
				valid_q[slot_q] <= 1'b1;
			end

			if (state_q == ST_EVAL) begin
				if (!rise_q) begin
					if (slot_q != SLOT_LAST) slot_q <= slot_q + SLOT_W'(1);
				end else begin
					last_rise_q <= time_q;
					if (is_sync) slot_q <= '0;
				end
			end

			// output register: load when the result is ready and the slot is free
			if (state_q == ST_OUT && out_free) m_tvalid_q <= 1'b1;
			else if (m_tready)                 m_tvalid_q <= 1'b0;
		end
	end

	// ---------------------------------------------------------------- datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rise_q <= s_tuser;
			time_q <= s_tdata;
		end

		if (state_q == ST_DIFF) begin
			diff_q <= time_q - last_rise_q;
		end

		if (state_q == ST_EVAL) begin
			res_q    <= res_eval;
			long_q   <= (slot_q >= MIN_SLOTS);
			walk_q   <= '0;
			ok_q     <= 1'b1;
			par_q    <= '0;
			min_q    <= '0;
			hour_q   <= '0;
			day_q    <= '0;
			wday_q   <= '0;
			mon_q    <= '0;
			year_q   <= '0;
			if (!rise_q) begin
				res_ev_q <= (zero_hit || one_hit) ? EV_BIT : EV_UNCLASS;
			end else begin
				res_ev_q <= EV_RISE;
			end
		end

		// issue one read a cycle
		if (state_q == ST_WALK) begin
			idx_s1  <= walk_q;
			vbit_s1 <= valid_q[walk_q];
			walk_q  <= walk_q + SLOT_W'(1);
		end

		// check and accumulate the slot whose symbol just came back
		if (vld_s1) begin
			if (idx_s1 == SLOT_START && !zero_s1)  ok_q <= 1'b0;
			if (idx_s1 == SLOT_TSTART && !one_s1)  ok_q <= 1'b0;
			if (idx_s1 == SLOT_ANT)  ant_zero_q <= zero_s1;
			if (idx_s1 == SLOT_ZCHG) zchg_q <= one_s1;
			if (idx_s1 == SLOT_CEST) begin
				s17_one_q  <= one_s1;
				s17_zero_q <= zero_s1;
			end
			if (idx_s1 == SLOT_CET) begin
				s18_one_q  <= one_s1;
				s18_zero_q <= zero_s1;
			end
			if (idx_s1 == SLOT_LEAP) leap_q <= one_s1;

			if (one_s1) begin
				if (idx_s1 >= SLOT_MIN0 && idx_s1 <= SLOT_PMIN)        par_q[0] <= !par_q[0];
				else if (idx_s1 >= SLOT_HOUR0 && idx_s1 <= SLOT_PHOUR) par_q[1] <= !par_q[1];
				else if (idx_s1 >= SLOT_DAY0 && idx_s1 <= SLOT_PDATE)  par_q[2] <= !par_q[2];

				case (fsel.fld)
					FLD_MIN:  min_q  <= acc_sum[6:0];
					FLD_HOUR: hour_q <= acc_sum[5:0];
					FLD_DAY:  day_q  <= acc_sum[5:0];
					FLD_WDAY: wday_q <= acc_sum[2:0];
					FLD_MON:  mon_q  <= acc_sum[4:0];
					FLD_YEAR: year_q <= acc_sum;
					default:  ;
				endcase
			end
		end

		// frame verdict
		if (state_q == ST_FIN) begin
			res_q    <= res_fin;
			res_ev_q <= frame_ok ? EV_VALID : EV_REJECT;
		end

		if (state_q == ST_OUT && out_free) begin
			m_ev_q   <= res_ev_q;
			m_data_q <= res_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_ev_q;
	assign m_tdata  = {(OUT_TDATA_W - RES_W)'(0), m_data_q};

endmodule
`default_nettype wire
